// File: rtl/ledrx_pkg.sv
package ledrx_pkg;

   // Frame geometry
   localparam int PIXELS = 150;
   localparam int PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int CNT_W  = $clog2(PIXELS + 1);
   localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
   localparam int ADDR_W = PIX_W + 1;
   localparam int DEPTH  = 2 << PIX_W;

   // Sync pair
   localparam logic [7:0] SYNC_FIRST  = 8'hFF;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;

   // Request kinds
   localparam logic [1:0] REQ_BYTE  = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_PIXEL = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_ACCEPT   = 2'd0;
   localparam logic [1:0] KIND_MISMATCH = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
   localparam logic [1:0] KIND_PIXEL    = 2'd3;

   // Register indexes and reset values
   localparam logic CSR_FRAME_PIXELS = 1'b0;
   localparam logic CSR_TIMEOUT_MS   = 1'b1;
   localparam logic [7:0] FRAME_PIXELS_RST = 8'd150;
   localparam logic [9:0] TIMEOUT_MS_RST   = 10'd50;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
   } evt_type;

   typedef struct packed {
      logic [2:0]        lane_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

endpackage

// File: rtl/ledrx_pixel_ram.sv
module ledrx_pixel_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ledrx_framer.sv
module ledrx_framer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   csr_addr,
   input  logic [9:0]             csr_wdata,
   input  logic                   accept,
   input  logic [1:0]             req_type,
   input  logic [7:0]             rx_byte,
   output logic                   busy,
   output logic                   shown_bank,
   output ledrx_pkg::evt_type     evt,
   output ledrx_pkg::mem_wr_type  mem_wr
);
   import ledrx_pkg::*;

   localparam logic [1:0] PH_SYNC1 = 2'd0;
   localparam logic [1:0] PH_SYNC2 = 2'd1;
   localparam logic [1:0] PH_DATA  = 2'd2;

   logic [7:0]       frame_pixels_ff;
   logic [9:0]       timeout_ms_ff;
   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] pix_cnt_ff, pix_cnt_in;
   logic [1:0]       lane_ff, lane_in;
   logic [7:0]       xor_ff, xor_in;
   logic [9:0]       ms_ff, ms_in;
   logic             shown_ff, shown_in;
   logic             busy_ff, busy_in;
   logic [PIX_W-1:0] clr_ptr_ff, clr_ptr_in;
   logic [CMP_W-1:0] fp_wide;
   logic [CNT_W-1:0] frame_len;

   // Clamp the frame length to 1..PIXELS
   always_comb begin
      fp_wide = CMP_W'(frame_pixels_ff);
      if (frame_pixels_ff == 8'd0) begin
         frame_len = CNT_W'(1);
      end else if (fp_wide > CMP_W'(PIXELS)) begin
         frame_len = CNT_W'(PIXELS);
      end else begin
         frame_len = CNT_W'(fp_wide);
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      pix_cnt_in = pix_cnt_ff;
      lane_in    = lane_ff;
      xor_in     = xor_ff;
      ms_in      = ms_ff;
      shown_in   = shown_ff;
      busy_in    = busy_ff;
      clr_ptr_in = clr_ptr_ff;
      evt        = '0;
      mem_wr.lane_en = 3'b000;
      mem_wr.addr    = {~shown_ff, pix_cnt_ff[PIX_W-1:0]};
      mem_wr.data    = rx_byte;

      if (busy_ff) begin
         // Clear bank zero, one row a cycle
         mem_wr.lane_en = 3'b111;
         mem_wr.addr    = {1'b0, clr_ptr_ff};
         mem_wr.data    = 8'd0;
         clr_ptr_in     = clr_ptr_ff + PIX_W'(1);
         if (clr_ptr_ff == PIX_W'(PIXELS - 1)) begin
            busy_in = 1'b0;
         end
      end else if (accept) begin
         case (req_type)
            REQ_BYTE: begin
               case (phase_ff)
                  PH_SYNC1: begin
                     if (rx_byte == SYNC_FIRST) begin
                        phase_in = PH_SYNC2;
                     end
                  end
                  PH_SYNC2: begin
                     if (rx_byte == SYNC_SECOND) begin
                        phase_in   = PH_DATA;
                        pix_cnt_in = '0;
                        lane_in    = 2'd0;
                        xor_in     = 8'd0;
                        ms_in      = 10'd0;
                     end else if (rx_byte != SYNC_FIRST) begin
                        phase_in = PH_SYNC1;
                     end
                  end
                  PH_DATA: begin
                     if (pix_cnt_ff < frame_len) begin
                        mem_wr.lane_en = 3'b001 << lane_ff;
                        xor_in = xor_ff ^ rx_byte;
                        if (lane_ff == 2'd2) begin
                           lane_in    = 2'd0;
                           pix_cnt_in = pix_cnt_ff + CNT_W'(1);
                        end else begin
                           lane_in = lane_ff + 2'd1;
                        end
                     end else begin
                        phase_in  = PH_SYNC1;
                        evt.valid = 1'b1;
                        if (xor_ff == rx_byte) begin
                           shown_in = ~shown_ff;
                           evt.kind = KIND_ACCEPT;
                        end else begin
                           evt.kind = KIND_MISMATCH;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_SYNC1;
                  end
               endcase
            end
            REQ_TICK: begin
               if (phase_ff == PH_DATA) begin
                  if (ms_ff >= timeout_ms_ff) begin
                     phase_in  = PH_SYNC1;
                     evt.valid = 1'b1;
                     evt.kind  = KIND_TIMEOUT;
                  end else begin
                     ms_in = ms_ff + 10'd1;
                  end
               end
            end
            REQ_PIXEL: begin
               evt.valid = 1'b1;
               evt.kind  = KIND_PIXEL;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff <= FRAME_PIXELS_RST;
         timeout_ms_ff   <= TIMEOUT_MS_RST;
         phase_ff        <= PH_SYNC1;
         pix_cnt_ff      <= '0;
         lane_ff         <= 2'd0;
         xor_ff          <= 8'd0;
         ms_ff           <= 10'd0;
         shown_ff        <= 1'b0;
         busy_ff         <= 1'b1;
         clr_ptr_ff      <= '0;
      end else begin
         if (csr_we && csr_addr == CSR_FRAME_PIXELS) begin
            frame_pixels_ff <= csr_wdata[7:0];
         end
         if (csr_we && csr_addr == CSR_TIMEOUT_MS) begin
            timeout_ms_ff <= csr_wdata;
         end
         phase_ff   <= phase_in;
         pix_cnt_ff <= pix_cnt_in;
         lane_ff    <= lane_in;
         xor_ff     <= xor_in;
         ms_ff      <= ms_in;
         shown_ff   <= shown_in;
         busy_ff    <= busy_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   assign busy       = busy_ff;
   assign shown_bank = shown_ff;

endmodule

// File: rtl/led_frame_stream_receiver.sv
// A request that raises an event passes through the response stage and then the output
// register before it shows on rsp_tvalid; a request that raises no event gives no response.
// Throughput: one request per cycle while req_tready is high (it drops during the clear
// and while a response stalls); each request makes at most one memory write and one
// three-lane memory read, with a response stage and an output register. Reset
// (synchronous, active high) clears control state, then bank zero of the pixel memory
// is cleared one row a cycle while req_tready stays low; configuration writes are taken throughout.
module led_frame_stream_receiver (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [15:8] pixel_index
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   // Configuration writes
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [9:0]  csr_wdata
);
   import ledrx_pkg::*;

   logic              accept;
   logic              busy;
   logic              shown_bank;
   evt_type           evt;
   mem_wr_type        mem_wr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_red, rd_green, rd_blue;
   logic              pix_in_range;

   // Response stage: holds the event of an accepted request until the output register takes it
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_kind_ff;
   logic       s1_inr_ff;
   logic       s1_advance;

   // Output register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff;
   logic [23:0] out_data_ff;

   // Advance the response stage whenever the output register frees up
   assign s1_advance = !out_valid_ff || rsp_tready;
   assign req_tready = !busy && (!s1_valid_ff || s1_advance);
   assign accept     = req_tvalid && req_tready;

   ledrx_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .req_type   (req_tuser),
      .rx_byte    (req_tdata[7:0]),
      .busy       (busy),
      .shown_bank (shown_bank),
      .evt        (evt),
      .mem_wr     (mem_wr)
   );

   // Pixel reads always hit the shown bank; frame writes hit the back bank, and the reset clear
   // of bank zero runs while requests are held off, so a read never races a write to the same row.
   assign rd_en        = accept && (req_tuser == REQ_PIXEL);
   assign rd_addr      = {shown_bank, req_tdata[8 +: PIX_W]};
   assign pix_in_range = CMP_W'(req_tdata[15:8]) < CMP_W'(PIXELS);

   ledrx_pixel_ram #(.WIDTH(8), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_red (
      .clock   (clock),
      .wr_en   (mem_wr.lane_en[0]),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_red)
   );

   ledrx_pixel_ram #(.WIDTH(8), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_green (
      .clock   (clock),
      .wr_en   (mem_wr.lane_en[1]),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_green)
   );

   ledrx_pixel_ram #(.WIDTH(8), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_blue (
      .clock   (clock),
      .wr_en   (mem_wr.lane_en[2]),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_blue)
   );

   // Load the response stage with each accepted request that raises an event; drop the slot when it
   // moves on with nothing behind it.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!s1_valid_ff || s1_advance) begin
         s1_valid_in = accept && evt.valid;
      end
      out_valid_in = out_valid_ff;
      if (s1_advance) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: hold while stalled, memory data is picked up as it leaves stage one
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= evt.kind;
         s1_inr_ff  <= pix_in_range;
      end
      if (s1_advance && s1_valid_ff) begin
         out_kind_ff <= s1_kind_ff;
         if (s1_kind_ff == KIND_PIXEL && s1_inr_ff) begin
            out_data_ff <= {rd_blue, rd_green, rd_red};
         end else begin
            out_data_ff <= 24'd0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: rtl/ledrx_checker.sv
module ledrx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_we,
   input logic        csr_addr,
   input logic [9:0]  csr_wdata
);
   import ledrx_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Frame status responses carry no colour
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_PIXEL |-> rsp_tdata == 24'd0)
      else $error("status response with nonzero colour");

   // Check that reset leaves req_tready low as the clear of the shown bank starts
   a_clear_stall: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request ready during reset clear");

   // A new response traces back through the response stage and output register to an accepted request
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without request");

endmodule

bind led_frame_stream_receiver ledrx_checker u_checker (.*);
